/* rtl/core/iclc_pkg.sv */
// shared types and constants for the integer literal classify and convert unit
`timescale 1ns / 1ps
`default_nettype none

package iclc_pkg;

	// widths of the request and result fields
	localparam int CHAR_BITS      = 8;
	localparam int VALUE_BITS     = 64;
	localparam int NARROW_BITS    = 32;
	localparam int VALUE_WIDTH_DEF = 64;

	// queue between the front and the back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// position saturates here
	localparam logic [1:0] POS_SAT = 2'd2;

	// literal classes as seen on the result channel
	typedef enum logic [2:0] {
		CLS_NONE  = 3'd0,
		CLS_DEC   = 3'd1,
		CLS_HEX   = 3'd2,
		CLS_OCT   = 3'd3,
		CLS_FLOAT = 3'd4
	} lit_class_t;

	// radix decided from the leading characters
	typedef enum logic [1:0] {
		RADIX_NONE = 2'd0,
		RADIX_DEC  = 2'd1,
		RADIX_HEX  = 2'd2,
		RADIX_OCT  = 2'd3
	} radix_t;

	// character kinds produced by the front
	typedef enum logic [2:0] {
		KIND_DIGIT,
		KIND_LETTER,
		KIND_POINT,
		KIND_LOWER_X,
		KIND_OTHER
	} char_kind_t;

	// one classified character in the queue
	typedef struct packed {
		char_kind_t kind;
		logic [3:0] digit;
		logic       last;
	} entry_t;

	// per-token scan state
	typedef struct packed {
		logic [1:0] position;
		radix_t     radix_mode;
		logic       first_was_zero;
		logic       int_valid;
		logic       float_valid;
		logic       point_seen;
		logic       hex_digit_seen;
	} tok_t;

	localparam tok_t TOK_CLEAR = '{
		position:       2'd0,
		radix_mode:     RADIX_NONE,
		first_was_zero: 1'b0,
		int_valid:      1'b1,
		float_valid:    1'b1,
		point_seen:     1'b0,
		hex_digit_seen: 1'b0
	};

endpackage

`default_nettype wire

/* rtl/core/iclc_char_if.sv */
// character request channel: one token character with its last mark
`timescale 1ns / 1ps
`default_nettype none

interface iclc_char_if;
	import iclc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CHAR_BITS-1:0] char_code;
	logic                 last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

/* rtl/core/iclc_res_if.sv */
// result channel: converted value and literal class
`timescale 1ns / 1ps
`default_nettype none

interface iclc_res_if;
	import iclc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;
	logic [2:0]            literal_class;

	modport source (output valid, output value, output literal_class, input ready);
	modport sink (input valid, input value, input literal_class, output ready);
endinterface

`default_nettype wire

/* rtl/core/iclc_queue.sv */
// short fifo of classified characters between front and back
`timescale 1ns / 1ps
`default_nettype none

module iclc_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  iclc_pkg::entry_t     push_data,
	output logic                 full,
	input  wire logic            pop,
	output iclc_pkg::entry_t     pop_data,
	output logic                 not_empty
);
	import iclc_pkg::*;

	entry_t                 mem_q [QUEUE_DEPTH];
	logic [QUEUE_IDX_W-1:0] wr_ptr_q;
	logic [QUEUE_IDX_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	// status
	assign full      = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

/* rtl/core/iclc_front.sv */
// front: accepts characters, classifies them and queues them for the back
`timescale 1ns / 1ps
`default_nettype none

module iclc_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	iclc_char_if.sink        chars,
	output logic             q_valid,
	output iclc_pkg::entry_t q_data,
	input  wire logic        q_pop
);
	import iclc_pkg::*;

	localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;
	localparam logic [CHAR_BITS-1:0] CHAR_UP_A  = 8'h41;
	localparam logic [CHAR_BITS-1:0] CHAR_UP_F  = 8'h46;
	localparam logic [CHAR_BITS-1:0] CHAR_LO_A  = 8'h61;
	localparam logic [CHAR_BITS-1:0] CHAR_LO_F  = 8'h66;
	localparam logic [CHAR_BITS-1:0] CHAR_POINT = 8'h2e;
	localparam logic [CHAR_BITS-1:0] CHAR_LO_X  = 8'h78;
	// letters a-f and A-F carry their value as low nibble plus nine
	localparam logic [3:0]           LETTER_OFS = 4'd9;

	entry_t cls_entry;
	logic   full;
	logic   push;

	// character classifier
	always_comb begin
		cls_entry.kind  = KIND_OTHER;
		cls_entry.digit = chars.char_code[3:0];
		cls_entry.last  = chars.last_char;
		if (chars.char_code >= CHAR_ZERO && chars.char_code <= CHAR_NINE) begin
			cls_entry.kind = KIND_DIGIT;
		end else if ((chars.char_code >= CHAR_UP_A && chars.char_code <= CHAR_UP_F) ||
		             (chars.char_code >= CHAR_LO_A && chars.char_code <= CHAR_LO_F)) begin
			cls_entry.kind  = KIND_LETTER;
			cls_entry.digit = chars.char_code[3:0] + LETTER_OFS;
		end else if (chars.char_code == CHAR_POINT) begin
			cls_entry.kind = KIND_POINT;
		end else if (chars.char_code == CHAR_LO_X) begin
			cls_entry.kind = KIND_LOWER_X;
		end
	end

	// accept whenever the queue has room
	assign chars.ready = !full;
	assign push        = chars.valid && !full;

	iclc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cls_entry),
		.full      (full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.not_empty (q_valid)
	);

endmodule

`default_nettype wire

/* rtl/core/iclc_back.sv */
// back: token scan state, accumulator and result register
`timescale 1ns / 1ps
`default_nettype none

module iclc_back #(
	parameter int VALUE_WIDTH = iclc_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        narrow_result,
	input  wire logic        q_valid,
	input  iclc_pkg::entry_t q_data,
	output logic             q_pop,
	iclc_res_if.source       results
);
	import iclc_pkg::*;

	tok_t                   tok_q;
	tok_t                   tok_nxt;
	logic [VALUE_WIDTH-1:0] acc_q;
	logic [VALUE_WIDTH-1:0] acc_scaled;
	logic [VALUE_WIDTH-1:0] acc_nxt;
	logic                   step_en;
	radix_t                 step_radix;
	lit_class_t             cls;
	logic [VALUE_BITS-1:0]  val_wide;
	logic [VALUE_BITS-1:0]  val_out;

	logic                  res_valid_q;
	logic [VALUE_BITS-1:0] res_value_q;
	lit_class_t            res_class_q;

	// take the next queued character when the result register is free
	assign q_pop = q_valid && (!res_valid_q || results.ready);

	// scan state update for one character
	always_comb begin
		tok_nxt    = tok_q;
		step_en    = 1'b0;
		step_radix = RADIX_DEC;
		if (tok_q.position == 2'd0) begin
			unique case (q_data.kind)
				KIND_DIGIT: begin
					if (q_data.digit == 4'd0) begin
						tok_nxt.first_was_zero = 1'b1;
					end else begin
						tok_nxt.radix_mode = RADIX_DEC;
						step_en            = 1'b1;
						step_radix         = RADIX_DEC;
					end
				end
				KIND_POINT: begin
					tok_nxt.point_seen = 1'b1;
					tok_nxt.int_valid  = 1'b0;
				end
				default: begin
					tok_nxt.int_valid   = 1'b0;
					tok_nxt.float_valid = 1'b0;
				end
			endcase
		end else if (tok_q.position == 2'd1 && tok_q.first_was_zero &&
		             tok_q.radix_mode == RADIX_NONE && q_data.kind == KIND_LOWER_X) begin
			// 0x prefix
			tok_nxt.radix_mode  = RADIX_HEX;
			tok_nxt.float_valid = 1'b0;
		end else begin
			// second character after a leading zero picks octal
			if (tok_q.position == 2'd1 && tok_q.first_was_zero &&
			    tok_q.radix_mode == RADIX_NONE && q_data.kind == KIND_DIGIT) begin
				if (q_data.digit <= 4'd7) begin
					tok_nxt.radix_mode = RADIX_OCT;
				end else begin
					tok_nxt.int_valid = 1'b0;
				end
			end
			unique case (q_data.kind)
				KIND_DIGIT: begin
					unique case (tok_nxt.radix_mode)
						RADIX_DEC: begin
							step_en    = 1'b1;
							step_radix = RADIX_DEC;
						end
						RADIX_HEX: begin
							step_en                = 1'b1;
							step_radix             = RADIX_HEX;
							tok_nxt.hex_digit_seen = 1'b1;
						end
						RADIX_OCT: begin
							if (q_data.digit <= 4'd7) begin
								step_en    = 1'b1;
								step_radix = RADIX_OCT;
							end else begin
								tok_nxt.int_valid = 1'b0;
							end
						end
						RADIX_NONE: begin
						end
					endcase
				end
				KIND_LETTER: begin
					tok_nxt.float_valid = 1'b0;
					if (tok_nxt.radix_mode == RADIX_HEX) begin
						step_en                = 1'b1;
						step_radix             = RADIX_HEX;
						tok_nxt.hex_digit_seen = 1'b1;
					end else begin
						tok_nxt.int_valid = 1'b0;
					end
				end
				KIND_POINT: begin
					if (tok_q.point_seen) begin
						tok_nxt.float_valid = 1'b0;
					end
					tok_nxt.point_seen = 1'b1;
					tok_nxt.int_valid  = 1'b0;
				end
				default: begin
					tok_nxt.int_valid   = 1'b0;
					tok_nxt.float_valid = 1'b0;
				end
			endcase
		end
		if (tok_q.position != POS_SAT) begin
			tok_nxt.position = tok_q.position + 2'd1;
		end
	end

	// accumulate by shift and add, wrapping at the value width
	always_comb begin
		unique case (step_radix)
			RADIX_HEX: acc_scaled = acc_q << 4;
			RADIX_OCT: acc_scaled = acc_q << 3;
			RADIX_DEC: acc_scaled = (acc_q << 3) + (acc_q << 1);
			default:   acc_scaled = acc_q;
		endcase
		acc_nxt = step_en ? acc_scaled + VALUE_WIDTH'(q_data.digit) : acc_q;
	end

	// final class of the token
	always_comb begin
		cls = CLS_NONE;
		if (tok_nxt.float_valid && tok_nxt.point_seen) begin
			cls = CLS_FLOAT;
		end else if (tok_nxt.int_valid) begin
			if (tok_nxt.radix_mode == RADIX_DEC) begin
				cls = CLS_DEC;
			end else if (tok_nxt.radix_mode == RADIX_NONE && tok_nxt.first_was_zero) begin
				cls = CLS_DEC;
			end else if (tok_nxt.radix_mode == RADIX_HEX && tok_nxt.hex_digit_seen) begin
				cls = CLS_HEX;
			end else if (tok_nxt.radix_mode == RADIX_OCT) begin
				cls = CLS_OCT;
			end
		end
	end

	// result value, optionally narrowed
	always_comb begin
		val_wide = VALUE_BITS'(acc_nxt);
		if (cls == CLS_NONE || cls == CLS_FLOAT) begin
			val_out = '0;
		end else if (narrow_result) begin
			val_out = {{(VALUE_BITS - NARROW_BITS){1'b0}}, val_wide[NARROW_BITS-1:0]};
		end else begin
			val_out = val_wide;
		end
	end

	// scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= TOK_CLEAR;
			acc_q <= '0;
		end else if (q_pop) begin
			if (q_data.last) begin
				tok_q <= TOK_CLEAR;
				acc_q <= '0;
			end else begin
				tok_q <= tok_nxt;
				acc_q <= acc_nxt;
			end
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (q_pop && q_data.last) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (q_pop && q_data.last) begin
			res_value_q <= val_out;
			res_class_q <= cls;
		end
	end

	assign results.valid         = res_valid_q;
	assign results.value         = res_value_q;
	assign results.literal_class = res_class_q;

	// checks
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_data.last) |=> (tok_q.position == 2'd0 && acc_q == '0))
		else $error("scan state not cleared after last character");
	a_float_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_class_q == CLS_FLOAT || res_class_q == CLS_NONE))
		|-> (res_value_q == '0))
		else $error("nonzero value for float or invalid token");
	a_narrow_upper: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_data.last && narrow_result)
		|=> (res_value_q[VALUE_BITS-1:NARROW_BITS] == '0))
		else $error("narrowed result has upper bits set");

endmodule

`default_nettype wire

/* rtl/core/integer_literal_classify_convert_unit.sv */
// Integer literal classify and convert unit, top level.
//
// Usage: characters of one numeric token arrive on the chars channel, one
// request per character, with last_char set on the final one. For each token
// one result leaves on the results channel: the converted value (wrapping
// modulo 2^VALUE_WIDTH, zero for float or invalid tokens) and its class
// (none, decimal, hex with 0x prefix, octal, float). Non-final characters
// produce no result. cfg_wr_en with cfg_wr_data[0] sets narrow_result, which
// keeps only the low 32 bits of the value; write it only while idle.
// A result is registered once its last character leaves the queue.
// Throughput: one character per cycle unless a stalled receiver holds the
// result register; the back stage accumulates by shift-and-add on the radix.
// A two-entry queue separates the classifying front from the back, so a
// stalled receiver stops the back first; chars.ready drops only once the
// queue is full. Reset clears the token state, the queue and narrow_result
// at once, with no clearing pass; the unit is ready right after reset.
`timescale 1ns / 1ps
`default_nettype none

module integer_literal_classify_convert_unit #(
	parameter int VALUE_WIDTH = iclc_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	iclc_char_if.sink  chars,
	iclc_res_if.source results,
	input  wire logic cfg_wr_en,
	input  wire logic cfg_wr_data
);
	import iclc_pkg::*;

	logic   narrow_q;
	logic   q_valid;
	logic   q_pop;
	entry_t q_data;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			narrow_q <= 1'b0;
		end else if (cfg_wr_en) begin
			narrow_q <= cfg_wr_data;
		end
	end

	iclc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop)
	);

	iclc_back #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.narrow_result (narrow_q),
		.q_valid       (q_valid),
		.q_data        (q_data),
		.q_pop         (q_pop),
		.results       (results)
	);

endmodule

`default_nettype wire

/* dv/integer_literal_classify_convert_unit_tb.sv */
// testbench for the integer literal classify and convert unit
`timescale 1ns / 1ps

module integer_literal_classify_convert_unit_tb;
	import iclc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 300;

	// ascii characters the scanner cares about
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_7 = 8'h37;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UF = 8'h46;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LF = 8'h66;
	localparam logic [7:0] CH_LX = 8'h78;
	localparam logic [7:0] CH_UX = 8'h58;
	localparam logic [7:0] CH_LG = 8'h67;
	localparam logic [7:0] CH_POINT = 8'h2e;

	typedef struct {
		logic [VALUE_BITS-1:0] value;
		lit_class_t            cls;
	} literal_result_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic cfg_wr_data;

	iclc_char_if chars_if ();
	iclc_res_if  res_if ();

	integer_literal_classify_convert_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars_if),
		.results    (res_if),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// mirror of the scanner state
	logic [1:0]            scan_pos;
	radix_t                scan_radix;
	bit                    first_zero;
	bit                    int_ok;
	bit                    float_ok;
	bit                    point_seen;
	bit                    hex_seen;
	logic [VALUE_BITS-1:0] acc;
	bit                    narrow_mode;

	literal_result_t expected_literals[$];
	logic [7:0]      token_buf[$];

	int mismatch_count = 0;
	int stall_cycles = 0;
	int src_idle_pct = 0;
	int dst_idle_pct = 0;
	int hold_cycles = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic clear_scan_state();
		scan_pos   = 2'd0;
		scan_radix = RADIX_NONE;
		first_zero = 1'b0;
		int_ok     = 1'b1;
		float_ok   = 1'b1;
		point_seen = 1'b0;
		hex_seen   = 1'b0;
		acc        = '0;
	endtask

	// advance the scanner by one character, queue the literal on the last one
	task automatic scan_literal_char(input logic [7:0] c, input logic last);
		bit                    is_digit;
		bit                    is_upper;
		bit                    is_lower;
		bit                    prefix_x;
		logic [VALUE_BITS-1:0] digit_val;
		literal_result_t       res;
		is_digit  = (c >= CH_0) && (c <= CH_9);
		is_upper  = (c >= CH_UA) && (c <= CH_UF);
		is_lower  = (c >= CH_LA) && (c <= CH_LF);
		prefix_x  = 1'b0;
		digit_val = VALUE_BITS'(c) - VALUE_BITS'(CH_0);
		if (scan_pos == 2'd0) begin
			if (c == CH_0) begin
				first_zero = 1'b1;
			end else if (is_digit) begin
				scan_radix = RADIX_DEC;
				acc = acc * 10 + digit_val;
			end else if (c == CH_POINT) begin
				point_seen = 1'b1;
				int_ok = 1'b0;
			end else begin
				int_ok = 1'b0;
				float_ok = 1'b0;
			end
		end else begin
			// second character after a leading zero picks hex or octal
			if (scan_pos == 2'd1 && first_zero && scan_radix == RADIX_NONE) begin
				if (c == CH_LX) begin
					scan_radix = RADIX_HEX;
					float_ok = 1'b0;
					prefix_x = 1'b1;
				end else if (is_digit) begin
					if (c <= CH_7)
						scan_radix = RADIX_OCT;
					else
						int_ok = 1'b0;
				end
			end
			if (!prefix_x) begin
				if (is_digit) begin
					case (scan_radix)
						RADIX_DEC: acc = acc * 10 + digit_val;
						RADIX_HEX: begin
							acc = acc * 16 + digit_val;
							hex_seen = 1'b1;
						end
						RADIX_OCT: begin
							if (digit_val <= 7)
								acc = acc * 8 + digit_val;
							else
								int_ok = 1'b0;
						end
						default: ;
					endcase
				end else if (is_upper || is_lower) begin
					float_ok = 1'b0;
					if (scan_radix == RADIX_HEX) begin
						acc = acc * 16 + VALUE_BITS'(c)
							- VALUE_BITS'(is_upper ? CH_UA : CH_LA) + 10;
						hex_seen = 1'b1;
					end else begin
						int_ok = 1'b0;
					end
				end else if (c == CH_POINT) begin
					if (point_seen)
						float_ok = 1'b0;
					point_seen = 1'b1;
					int_ok = 1'b0;
				end else begin
					int_ok = 1'b0;
					float_ok = 1'b0;
				end
			end
		end
		if (scan_pos != POS_SAT)
			scan_pos = scan_pos + 2'd1;
		if (last) begin
			res.cls = CLS_NONE;
			res.value = '0;
			if (float_ok && point_seen) begin
				res.cls = CLS_FLOAT;
			end else if (int_ok) begin
				if (scan_radix == RADIX_DEC)
					res.cls = CLS_DEC;
				else if (scan_radix == RADIX_NONE && first_zero)
					res.cls = CLS_DEC;
				else if (scan_radix == RADIX_HEX && hex_seen)
					res.cls = CLS_HEX;
				else if (scan_radix == RADIX_OCT)
					res.cls = CLS_OCT;
			end
			if (res.cls == CLS_DEC || res.cls == CLS_HEX || res.cls == CLS_OCT) begin
				res.value = acc;
				if (narrow_mode)
					res.value = {{(VALUE_BITS-NARROW_BITS){1'b0}}, acc[NARROW_BITS-1:0]};
			end
			expected_literals.push_back(res);
			clear_scan_state();
		end
	endtask

	// monitor: check results, predict from accepted requests, watchdog
	always @(posedge clk) begin
		literal_result_t exp_res;
		if (arst_n) begin
			if (cfg_wr_en)
				narrow_mode = cfg_wr_data;
			if (res_if.valid && res_if.ready) begin
				if (expected_literals.size() == 0) begin
					$display("%0t: result with nothing pending, actual value %h class %0d",
						$time, res_if.value, res_if.literal_class);
					mismatch_count++;
				end else begin
					exp_res = expected_literals.pop_front();
					if (res_if.value !== exp_res.value) begin
						$display("%0t: value mismatch, expected %h, actual %h",
							$time, exp_res.value, res_if.value);
						mismatch_count++;
					end
					if (res_if.literal_class !== exp_res.cls) begin
						$display("%0t: class mismatch, expected %0d, actual %0d",
							$time, exp_res.cls, res_if.literal_class);
						mismatch_count++;
					end
				end
			end
			if (chars_if.valid && chars_if.ready)
				scan_literal_char(chars_if.char_code, chars_if.last_char);
			if ((chars_if.valid && chars_if.ready) || (res_if.valid && res_if.ready)
					|| cfg_wr_en)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, stall_cycles);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// result receiver: random stalls, or a long hold-off when asked
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_cycles > 0) begin
				res_if.ready <= 1'b0;
				hold_cycles--;
			end else begin
				res_if.ready <= ($urandom_range(99) >= dst_idle_pct);
			end
		end
	end

	// offer one request; valid stays up after acceptance until the next call
	task automatic send_char(input logic [7:0] c, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			chars_if.valid <= 1'b0;
			@(negedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.char_code <= c;
		chars_if.last_char <= last;
		@(posedge clk);
		while (!chars_if.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_token();
		foreach (token_buf[i])
			send_char(token_buf[i], i == token_buf.size() - 1);
		token_buf.delete();
	endtask

	task automatic send_text(input string s);
		token_buf.delete();
		for (int i = 0; i < s.len(); i++)
			token_buf.push_back(s[i]);
		send_token();
	endtask

	// stop offering and wait for every pending literal to come back
	task automatic drain_results();
		chars_if.valid <= 1'b0;
		while (expected_literals.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_narrow(input bit on);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= on;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [7:0] rand_dec_char();
		return CH_0 + 8'($urandom_range(9));
	endfunction

	function automatic logic [7:0] rand_hex_char();
		case ($urandom_range(2))
			0: return CH_0 + 8'($urandom_range(9));
			1: return CH_LA + 8'($urandom_range(5));
			default: return CH_UA + 8'($urandom_range(5));
		endcase
	endfunction

	// mostly short tokens, now and then a long one that may wrap
	function automatic int rand_len();
		if ($urandom_range(15) == 0)
			return $urandom_range(24, 8);
		return $urandom_range(6, 1);
	endfunction

	// well-formed token, kind chosen by pick in 0..74
	task automatic build_well_formed(input int pick);
		int len;
		int point_at;
		len = rand_len();
		token_buf.delete();
		if (pick < 20) begin
			token_buf.push_back(CH_0 + 8'($urandom_range(9, 1)));
			repeat (len - 1) token_buf.push_back(rand_dec_char());
		end else if (pick < 40) begin
			token_buf.push_back(CH_0);
			token_buf.push_back(CH_LX);
			repeat (len) token_buf.push_back(rand_hex_char());
		end else if (pick < 55) begin
			token_buf.push_back(CH_0);
			repeat (len) token_buf.push_back(CH_0 + 8'($urandom_range(7)));
		end else if (pick < 70) begin
			point_at = $urandom_range(len);
			for (int i = 0; i <= len; i++)
				token_buf.push_back(i == point_at ? CH_POINT : rand_dec_char());
		end else begin
			token_buf.push_back(CH_0);
		end
	endtask

	task automatic build_random_token();
		int pick;
		int len;
		pick = $urandom_range(99);
		if (pick < 75) begin
			build_well_formed(pick);
		end else if (pick < 90) begin
			// a well-formed token with one character spoiled
			build_well_formed($urandom_range(74));
			case ($urandom_range(7))
				0: token_buf[$urandom_range(token_buf.size() - 1)] = CH_9 - 8'd1;
				1: token_buf[$urandom_range(token_buf.size() - 1)] = CH_9;
				2: token_buf[$urandom_range(token_buf.size() - 1)] = CH_POINT;
				3: token_buf[$urandom_range(token_buf.size() - 1)] = CH_LX;
				4: token_buf[$urandom_range(token_buf.size() - 1)] = CH_UX;
				5: token_buf[$urandom_range(token_buf.size() - 1)] = CH_LG;
				6: token_buf[$urandom_range(token_buf.size() - 1)] = CH_UF;
				default: token_buf[$urandom_range(token_buf.size() - 1)] =
					8'($urandom_range(255));
			endcase
		end else begin
			// raw bytes
			len = $urandom_range(6, 1);
			token_buf.delete();
			repeat (len) token_buf.push_back(8'($urandom_range(255)));
		end
	endtask

	// corner tokens: lone zero, prefixes, octal, float, double point, byte extremes
	task automatic test_directed();
		src_idle_pct = 36;
		dst_idle_pct = 85;
		send_text("0");
		send_text("42");
		send_text("0x");
		send_text("0X");
		send_text("0xaF");
		send_text("07");
		send_text("08");
		send_text(".5");
		send_text("1..");
		token_buf.push_back(8'h00);
		send_token();
		token_buf.push_back(8'hff);
		send_token();
	endtask

	// long tokens in every radix so the accumulator wraps, wide and narrow
	task automatic test_wraparound();
		for (int pass = 0; pass < 2; pass++) begin
			write_narrow(pass == 1);
			send_text("99999999999999999999");
			repeat (21) token_buf.push_back(rand_dec_char());
			token_buf[0] = CH_9;
			send_token();
			token_buf.push_back(CH_0);
			token_buf.push_back(CH_LX);
			repeat (18) token_buf.push_back(rand_hex_char());
			send_token();
			token_buf.push_back(CH_0);
			token_buf.push_back(CH_7);
			repeat (22) token_buf.push_back(CH_0 + 8'($urandom_range(7)));
			send_token();
		end
	endtask

	task automatic test_random_phase(input int n_items, input int src_pct,
			input int dst_pct, input bit narrow);
		int sent;
		write_narrow(narrow);
		src_idle_pct = src_pct;
		dst_idle_pct = dst_pct;
		sent = 0;
		while (sent < n_items) begin
			build_random_token();
			sent += token_buf.size();
			send_token();
		end
	endtask

	// receiver holds off while requests keep coming, then the sender pauses
	task automatic test_backpressure();
		int sent;
		write_narrow(1'b0);
		src_idle_pct = 0;
		dst_idle_pct = 0;
		hold_cycles = HOLD_OFF_CYCLES;
		sent = 0;
		while (sent < 80) begin
			build_random_token();
			sent += token_buf.size();
			send_token();
		end
		drain_results();
		sent = 0;
		while (sent < 40) begin
			build_random_token();
			sent += token_buf.size();
			send_token();
		end
	endtask

	// sequence of tests
	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.char_code = '0;
		chars_if.last_char = 1'b0;
		res_if.ready = 1'b0;
		narrow_mode = 1'b0;
		clear_scan_state();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_wraparound();
		test_random_phase(275, 36, 85, 1'b1);
		test_random_phase(275, 85, 36, 1'b0);
		test_random_phase(275, 0, 0, 1'b1);
		test_backpressure();
		drain_results();
		repeat (8) @(negedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
